// ===== rtl/skc_pkg.sv =====
// shared types and constants for the solitaire keystream cipher
package skc_pkg;

    localparam int DECK_N = 54;
    localparam logic [5:0] JOKER_A = 6'd53;
    localparam logic [5:0] JOKER_B = 6'd54;
    localparam logic [4:0] ALPHA = 5'd26;
    localparam int MAX_ROUNDS = 64;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FIND_A,
        ST_MOVE_A,
        ST_FIND_B,
        ST_MOVE_B,
        ST_FIND_AB,
        ST_CUT3,
        ST_COPY3,
        ST_BOT,
        ST_CUTC,
        ST_COPYC,
        ST_TOP,
        ST_PICK,
        ST_RESULT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start_find_a;
        logic start_find_b;
        logic start_find_ab;
        logic start_move_a;
        logic start_move_b;
        logic start_cut3;
        logic start_copy;
        logic start_cutc;
        logic rd_bottom;
        logic rd_top;
        logic rd_pick;
        logic do_load;
        logic do_result;
        logic do_zero;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic skip_cut3;
        logic skip_cutc;
        logic is_joker;
    } sts_t;

    function automatic logic [5:0] count_of(input logic [5:0] v);
        return (v > JOKER_A) ? JOKER_A : v;
    endfunction

    // ((v + 25) mod 26) + 1 for 6-bit v
    function automatic logic [4:0] reduce26(input logic [5:0] v);
        logic [6:0] t;
        t = {1'b0, v} + 7'd25;
        if (t >= 7'd78)
            t = t - 7'd78;
        else if (t >= 7'd52)
            t = t - 7'd52;
        else if (t >= 7'd26)
            t = t - 7'd26;
        return t[4:0] + 5'd1;
    endfunction

endpackage

// ===== rtl/solitaire_keystream_cipher.sv =====
// top level of the solitaire keystream cipher
// Usage:
//   in channel (in_valid/in_stall): kind 0 loads card_value at position,
//   kind 1 ciphers letter with the next keystream value. All 54 positions
//   must be loaded before the first letter.
//   out channel (out_valid/out_stall): one result per request; out_letter
//   and keystream_value are 0 after a load.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): decrypt_mode, 0 encrypt,
//   1 decrypt; write only while idle.
// Sequence: a letter runs keystream rounds, each a series of sweeps over
//   the single-read deck memory (three joker searches, triple cut and
//   copy, count cut and copy) plus the two joker moves and three single
//   reads. Joker outputs repeat the round, up to 64 rounds in all; a load
//   returns its result without running any round.
// One request is worked at a time; in_stall is high from accept until the
//   result has been taken. A stalled result holds on the outputs.
// Reset clears the controller and decrypt_mode; deck contents stay
//   undefined until loaded.
module solitaire_keystream_cipher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [5:0] position,
    input  logic [5:0] card_value,
    input  logic [4:0] letter,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] out_letter,
    output logic [4:0] keystream_value,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import skc_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    logic       idle, no_key, in_fire, out_fire;
    logic       dm_reg;
    logic       kind_reg;
    logic [5:0] pos_reg, card_reg;
    logic [4:0] let_reg;

    assign in_stall = !idle;
    assign in_fire = in_valid && idle;
    assign out_fire = out_valid && !out_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dm_reg <= 1'b0;
        else if (cfg_valid)
            dm_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= kind;
            pos_reg <= position;
            card_reg <= card_value;
            let_reg <= letter;
        end
    end

    skc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .kind(kind),
        .out_fire(out_fire), .sts(sts), .cmd(cmd), .idle(idle),
        .out_valid(out_valid), .no_key(no_key));

    skc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .position(pos_reg), .card_value(card_reg), .letter(let_reg),
        .decrypt_mode(dm_reg), .no_key(no_key),
        .out_letter(out_letter), .keystream_value(keystream_value));

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> kind_reg == $past(kind))
        else $error("request kind not captured");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("accepting while a result waits");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> dm_reg == $past(cfg_data))
        else $error("mode write lost");

endmodule

// ===== rtl/skc_ram.sv =====
// generic ram with one write port and one registered read port
module skc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 54
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/skc_datapath.sv =====
// deck storage and sequenced deck operations
module skc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  skc_pkg::cmd_t      cmd,
    output skc_pkg::sts_t      sts,
    input  logic [5:0]         position,
    input  logic [5:0]         card_value,
    input  logic [4:0]         letter,
    input  logic               decrypt_mode,
    input  logic               no_key,
    output logic [4:0]         out_letter,
    output logic [4:0]         keystream_value
);
    import skc_pkg::*;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FIND,
        OP_MOVE,
        OP_CUT,
        OP_COPY,
        OP_READ
    } op_t;

    // main deck and scratch deck
    logic       m_we, s_we;
    logic [5:0] m_wa, m_ra, s_wa, s_ra;
    logic [5:0] m_wd, s_wd, m_rd, s_rd;

    skc_ram #(.WIDTH(6), .DEPTH(DECK_N)) u_main (
        .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
    skc_ram #(.WIDTH(6), .DEPTH(DECK_N)) u_tmp (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

    op_t        op_reg, op_next;
    logic [5:0] i_reg, i_next;        // read index
    logic       pv_reg, pv_next;      // read data valid
    logic [5:0] pi_reg, pi_next;      // index of data now on rdata
    logic [5:0] lim_reg, lim_next;    // last index
    logic [5:0] tgt_reg, tgt_next;    // card searched
    logic [6:0] pa_reg, pa_next;      // position of a, 7'h7f absent
    logic [6:0] pb_reg, pb_next;
    logic       fab_reg, fab_next;    // searching both
    logic [5:0] mc_reg, mc_next;      // moved card
    logic [5:0] from_reg, from_next;
    logic [5:0] to_reg, to_next;
    logic       dn_reg, dn_next;      // moving down
    logic [5:0] cn_reg, cn_next;      // count cut n
    logic [5:0] rd_reg, rd_next;      // latched read value
    logic [4:0] ol_reg, ol_next, ks_reg, ks_next;
    logic [5:0] f_w, s_w;

    assign f_w = (pa_reg < pb_reg) ? pa_reg[5:0] : pb_reg[5:0];
    assign s_w = (pa_reg < pb_reg) ? pb_reg[5:0] : pa_reg[5:0];

    // triple cut destination of source index pi
    function automatic logic [5:0] cut3_dst(input logic [5:0] p, input logic [5:0] f,
                                            input logic [5:0] s);
        logic [5:0] r;
        if (p > s)
            r = p - s - 6'd1;
        else if (p >= f)
            r = p + 6'd53 - s - f;
        else
            r = p + 6'd54 - f;
        return r;
    endfunction

    function automatic logic [4:0] res_letter(input logic [4:0] l, input logic [4:0] k,
                                              input logic dm);
        logic [6:0] t;
        // letter + 25 +/- k, then reduce mod 26 and add 1
        if (dm)
            t = {2'b0, l} + 7'd51 - {2'b0, k};
        else
            t = {2'b0, l} + {2'b0, k} + 7'd25;
        if (t >= 7'd78)
            t = t - 7'd78;
        else if (t >= 7'd52)
            t = t - 7'd52;
        else if (t >= 7'd26)
            t = t - 7'd26;
        return t[4:0] + 5'd1;
    endfunction

    always_comb
    begin
        op_next = op_reg;
        i_next = i_reg;
        pv_next = 1'b0;
        pi_next = i_reg;
        lim_next = lim_reg;
        tgt_next = tgt_reg;
        pa_next = pa_reg;
        pb_next = pb_reg;
        fab_next = fab_reg;
        mc_next = mc_reg;
        from_next = from_reg;
        to_next = to_reg;
        dn_next = dn_reg;
        cn_next = cn_reg;
        rd_next = rd_reg;
        ol_next = ol_reg;
        ks_next = ks_reg;
        m_we = 1'b0;
        m_wa = position;
        m_wd = card_value;
        m_ra = i_reg;
        s_we = 1'b0;
        s_wa = pi_reg;
        s_wd = m_rd;
        s_ra = i_reg;

        unique case (op_reg)
            OP_NONE: ;
            OP_FIND:
            begin
                if (i_reg != 6'd63)
                begin
                    pv_next = 1'b1;
                    i_next = (i_reg == lim_reg) ? 6'd63 : i_reg + 6'd1;
                end
                if (pv_reg)
                begin
                    if (fab_reg)
                    begin
                        if (m_rd == JOKER_A && pa_reg == 7'h7f)
                            pa_next = {1'b0, pi_reg};
                        if (m_rd == JOKER_B && pb_reg == 7'h7f)
                            pb_next = {1'b0, pi_reg};
                    end
                    else if (m_rd == tgt_reg && pa_reg == 7'h7f)
                    begin
                        // single search marks both so absence reads the same way
                        pa_next = {1'b0, pi_reg};
                        pb_next = {1'b0, pi_reg};
                    end
                end
                if (!pv_reg && i_reg == 6'd63)
                    op_next = OP_NONE;
            end
            OP_MOVE:
            begin
                // shift each card between from and to a step toward from, then drop the moved card at to
                if (i_reg != 6'd63)
                begin
                    pv_next = 1'b1;
                    if (i_reg == lim_reg)
                        i_next = 6'd63;
                    else
                        i_next = dn_reg ? i_reg + 6'd1 : i_reg - 6'd1;
                end
                if (pv_reg)
                begin
                    m_we = 1'b1;
                    m_wa = dn_reg ? pi_reg - 6'd1 : pi_reg + 6'd1;
                    m_wd = m_rd;
                end
                if (!pv_reg && i_reg == 6'd63)
                begin
                    m_we = 1'b1;
                    m_wa = to_reg;
                    m_wd = mc_reg;
                    op_next = OP_NONE;
                end
            end
            OP_CUT:
            begin
                // main -> scratch at rearranged places
                if (i_reg != 6'd63)
                begin
                    pv_next = 1'b1;
                    i_next = (i_reg == lim_reg) ? 6'd63 : i_reg + 6'd1;
                end
                if (pv_reg)
                begin
                    s_we = 1'b1;
                    s_wd = m_rd;
                    if (cn_reg == 6'd0)
                        s_wa = cut3_dst(pi_reg, f_w, s_w);
                    else if (pi_reg == 6'd53)
                        s_wa = pi_reg;
                    else if (pi_reg >= cn_reg)
                        s_wa = pi_reg - cn_reg;
                    else
                        s_wa = pi_reg + 6'd53 - cn_reg;
                end
                if (!pv_reg && i_reg == 6'd63)
                    op_next = OP_NONE;
            end
            OP_COPY:
            begin
                if (i_reg != 6'd63)
                begin
                    pv_next = 1'b1;
                    i_next = (i_reg == lim_reg) ? 6'd63 : i_reg + 6'd1;
                end
                if (pv_reg)
                begin
                    m_we = 1'b1;
                    m_wa = pi_reg;
                    m_wd = s_rd;
                end
                if (!pv_reg && i_reg == 6'd63)
                    op_next = OP_NONE;
            end
            OP_READ:
            begin
                if (pv_reg)
                begin
                    rd_next = m_rd;
                    op_next = OP_NONE;
                end
                else
                    pv_next = 1'b1;
            end
            default: op_next = OP_NONE;
        endcase

        if (cmd.do_load)
            m_we = (position < 6'(DECK_N));
        if (cmd.start_find_a || cmd.start_find_b || cmd.start_find_ab)
        begin
            op_next = OP_FIND;
            i_next = 6'd0;
            lim_next = 6'(DECK_N - 1);
            tgt_next = cmd.start_find_b ? JOKER_B : JOKER_A;
            fab_next = cmd.start_find_ab;
            pa_next = 7'h7f;
            pb_next = 7'h7f;
        end
        if (cmd.start_move_a || cmd.start_move_b)
        begin
            from_next = pa_reg[5:0];
            if (cmd.start_move_a)
                to_next = (pa_reg[5:0] < 6'(DECK_N - 1)) ? pa_reg[5:0] + 6'd1 : 6'd1;
            else
                to_next = (pa_reg[5:0] < 6'(DECK_N - 2)) ? pa_reg[5:0] + 6'd2
                                                         : pa_reg[5:0] - 6'd51;
            mc_next = cmd.start_move_a ? JOKER_A : JOKER_B;
            dn_next = (to_next > from_next);
            op_next = OP_MOVE;
            // cards from+1..to move up, or to..from-1 move down one place
            i_next = dn_next ? from_next + 6'd1 : from_next - 6'd1;
            lim_next = to_next;
        end
        if (cmd.start_cut3)
        begin
            op_next = OP_CUT;
            cn_next = 6'd0;
            i_next = 6'd0;
            lim_next = 6'(DECK_N - 1);
        end
        if (cmd.start_cutc)
        begin
            op_next = OP_CUT;
            cn_next = count_of(rd_reg);
            i_next = 6'd0;
            lim_next = 6'(DECK_N - 1);
        end
        if (cmd.start_copy)
        begin
            op_next = OP_COPY;
            i_next = 6'd0;
            lim_next = 6'(DECK_N - 1);
        end
        if (cmd.rd_bottom || cmd.rd_top || cmd.rd_pick)
        begin
            op_next = OP_READ;
            pv_next = 1'b0;
            if (cmd.rd_bottom)
                i_next = 6'(DECK_N - 1);
            else if (cmd.rd_top)
                i_next = 6'd0;
            else
                i_next = count_of(rd_reg);
        end
        if (cmd.do_result)
        begin
            ks_next = no_key ? 5'd0 : reduce26(rd_reg);
            ol_next = res_letter(letter, ks_next, decrypt_mode);
        end
        if (cmd.do_zero)
        begin
            ks_next = 5'd0;
            ol_next = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_NONE;
            pv_reg <= 1'b0;
            i_reg <= 6'd63;
        end
        else
        begin
            op_reg <= op_next;
            pv_reg <= pv_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg <= pi_next;
        lim_reg <= lim_next;
        tgt_reg <= tgt_next;
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        fab_reg <= fab_next;
        mc_reg <= mc_next;
        from_reg <= from_next;
        to_reg <= to_next;
        dn_reg <= dn_next;
        cn_reg <= cn_next;
        rd_reg <= rd_next;
        ol_reg <= ol_next;
        ks_reg <= ks_next;
    end

    always_comb
    begin
        sts.busy = (op_reg != OP_NONE);
        sts.skip_cut3 = (pa_reg == 7'h7f) || (pb_reg == 7'h7f);
        sts.skip_cutc = (count_of(rd_reg) == 6'd0) || (count_of(rd_reg) == 6'(DECK_N - 1));
        sts.is_joker = (rd_reg == JOKER_A) || (rd_reg == JOKER_B);
    end

    assign out_letter = ol_reg;
    assign keystream_value = ks_reg;

endmodule

// ===== rtl/skc_ctrl.sv =====
// sequencer for loads and keystream rounds
module skc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           kind,
    input  logic           out_fire,
    input  skc_pkg::sts_t  sts,
    output skc_pkg::cmd_t  cmd,
    output logic           idle,
    output logic           out_valid,
    output logic           no_key
);
    import skc_pkg::*;

    state_t     state_reg, state_next;
    logic [6:0] rnd_reg, rnd_next;
    logic       run_reg, run_next;   // step issued, waiting for datapath

    always_comb
    begin
        state_next = state_reg;
        rnd_next = rnd_reg;
        run_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    state_next = kind ? ST_FIND_A : ST_LOAD;
                    rnd_next = 7'd0;
                end
            ST_LOAD: state_next = ST_OUT;
            ST_FIND_A, ST_MOVE_A, ST_FIND_B, ST_MOVE_B, ST_FIND_AB, ST_CUT3,
            ST_COPY3, ST_BOT, ST_CUTC, ST_COPYC, ST_TOP, ST_PICK:
            begin
                run_next = 1'b1;
                if (run_reg && !sts.busy)
                begin
                    run_next = 1'b0;
                    unique case (state_reg)
                        ST_FIND_A: state_next = sts.skip_cut3 ? ST_FIND_B : ST_MOVE_A;
                        ST_MOVE_A: state_next = ST_FIND_B;
                        ST_FIND_B: state_next = sts.skip_cut3 ? ST_FIND_AB : ST_MOVE_B;
                        ST_MOVE_B: state_next = ST_FIND_AB;
                        ST_FIND_AB: state_next = sts.skip_cut3 ? ST_BOT : ST_CUT3;
                        ST_CUT3: state_next = ST_COPY3;
                        ST_COPY3: state_next = ST_BOT;
                        ST_BOT: state_next = sts.skip_cutc ? ST_TOP : ST_CUTC;
                        ST_CUTC: state_next = ST_COPYC;
                        ST_COPYC: state_next = ST_TOP;
                        ST_TOP: state_next = ST_PICK;
                        ST_PICK:
                        begin
                            rnd_next = rnd_reg + 7'd1;
                            if (!sts.is_joker || rnd_next == 7'(MAX_ROUNDS))
                                state_next = ST_RESULT;
                            else
                                state_next = ST_FIND_A;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RESULT: state_next = ST_OUT;
            ST_OUT:
                if (out_fire)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        if (!run_reg)
        begin
            unique case (state_reg)
                ST_FIND_A: cmd.start_find_a = 1'b1;
                ST_MOVE_A: cmd.start_move_a = 1'b1;
                ST_FIND_B: cmd.start_find_b = 1'b1;
                ST_MOVE_B: cmd.start_move_b = 1'b1;
                ST_FIND_AB: cmd.start_find_ab = 1'b1;
                ST_CUT3: cmd.start_cut3 = 1'b1;
                ST_COPY3, ST_COPYC: cmd.start_copy = 1'b1;
                ST_BOT: cmd.rd_bottom = 1'b1;
                ST_CUTC: cmd.start_cutc = 1'b1;
                ST_TOP: cmd.rd_top = 1'b1;
                ST_PICK: cmd.rd_pick = 1'b1;
                default: ;
            endcase
        end
        cmd.do_load = (state_reg == ST_LOAD);
        cmd.do_zero = (state_reg == ST_LOAD);
        cmd.do_result = (state_reg == ST_RESULT);
    end

    assign idle = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign no_key = sts.is_joker;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg <= 7'd0;
            run_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            run_reg <= run_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.start_find_a, cmd.start_find_b, cmd.start_find_ab,
                    cmd.start_move_a, cmd.start_move_b, cmd.start_cut3,
                    cmd.start_copy, cmd.start_cutc, cmd.rd_bottom, cmd.rd_top,
                    cmd.rd_pick}) <= 1)
        else $error("several datapath commands at once");
    a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg <= 7'(MAX_ROUNDS))
        else $error("round counter overran");
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESULT |=> state_reg == ST_OUT)
        else $error("result not presented");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && !out_fire |=> state_reg == ST_OUT)
        else $error("result dropped while stalled");

endmodule
